// ===== rtl/core/dpp_pkg.sv =====
// shared types and constants of the deadline packet pacer
`default_nettype none

package dpp_pkg;

    localparam int TIME_W   = 64;
    localparam int CNT_W    = 40;
    localparam int NB_W     = 7;
    localparam int PERIOD_W = 50;
    localparam int TOL_W    = 32;
    localparam int PAY_W    = 16;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;
    localparam int RIDX_W   = 3;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    localparam logic [1:0] VERDICT_OK    = 2'd0;
    localparam logic [1:0] VERDICT_SHORT = 2'd1;
    localparam logic [1:0] VERDICT_LATE  = 2'd2;

    localparam logic [RIDX_W-1:0] REG_PERIOD   = 3'd0;
    localparam logic [RIDX_W-1:0] REG_BATCH    = 3'd1;
    localparam logic [RIDX_W-1:0] REG_BUDGET   = 3'd2;
    localparam logic [RIDX_W-1:0] REG_TOL      = 3'd3;
    localparam logic [RIDX_W-1:0] REG_MAX_LATE = 3'd4;
    localparam logic [RIDX_W-1:0] REG_PAYLOAD  = 3'd5;

    localparam logic [PAY_W-1:0] STAMP_MIN_BYTES = 16'd8;

    typedef struct packed {
        logic [1:0]        func;
        logic [TIME_W-1:0] now_time;
        logic              sink_ready;
    } in_t;

    typedef struct packed {
        logic              pkt_valid;
        logic [CNT_W-1:0]  seq_number;
        logic              stamp_seq;
        logic              last_of_batch;
        logic              batch_late;
        logic [TIME_W-1:0] lateness;
        logic [CNT_W-1:0]  packets_sent;
        logic [CNT_W-1:0]  late_count;
        logic [TIME_W-1:0] worst_lateness;
        logic [TIME_W-1:0] sum_lateness;
        logic              run_done;
        logic [1:0]        verdict;
    } out_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] packet_period;
        logic [NB_W-1:0]     batch_size;
        logic [CNT_W-1:0]    total_batches;
        logic [TOL_W-1:0]    late_tolerance;
        logic [CNT_W-1:0]    max_late_batches;
        logic [PAY_W-1:0]    payload_bytes;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        packet_period:    50'd1048576000,
        batch_size:       7'd1,
        total_batches:    40'd1,
        late_tolerance:   32'd5000,
        max_late_batches: 40'd0,
        payload_bytes:    16'd8972
    };

    // one released batch or one stop status, as handed from front to back
    typedef struct packed {
        logic              pkt;
        logic [NB_W-1:0]   nb;
        logic [CNT_W-1:0]  bidx;
        logic              stamp;
        logic              late;
        logic [TIME_W-1:0] lateness;
        logic [CNT_W-1:0]  sent_base;
        logic [CNT_W-1:0]  late_count;
        logic [TIME_W-1:0] worst;
        logic [TIME_W-1:0] sum;
        logic              done;
        logic [1:0]        verdict;
    } job_t;

    typedef struct packed {
        logic              load;
        logic [TIME_W-1:0] load_time;
        logic              kick;
        logic [CNT_W-1:0]  bidx;
        logic [NB_W-1:0]   nb;
    } dl_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/deadline_packet_pacer_unit.sv =====
// top level of the deadline packet pacer: register port and front/queue/back wiring
`default_nettype none

// Constant-rate packet pacer working from absolute deadlines. Items enter through a
// push/full queue port: start latches now_time as the time base and clears the counters,
// a time step releases the next batch once now_time reaches the deadline and the sink is
// ready, stop ends the run with one status beat. Result beats leave through an
// empty/pop queue port, one descriptor per packet, the last one of a batch carrying
// run_done and the verdict. The input side takes one item per cycle while full is low;
// full is raised while the job queue is full and, after a batch release, while the next
// deadline, base plus the rounded product of packet count and fixed-point period, runs
// through the multiply pipeline. The output side delivers one beat per cycle while the
// sink keeps popping, and up to QUEUE_DEPTH released batches wait in between.
// Registers sit at byte address 8*i on the 64-bit configuration port.

module deadline_packet_pacer_unit
    import dpp_pkg::*;
#(
    parameter int MAX_BATCH        = 64,
    parameter int PERIOD_FRAC_BITS = 20,
    parameter int QUEUE_DEPTH      = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire in_t               item,
    output logic                   empty,
    input  wire logic              pop,
    output out_t                   result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    cfg_t              cfg_reg, cfg_next;
    logic [RIDX_W-1:0] reg_idx;
    logic              cfg_wr;

    logic job_valid, q_full, q_empty, q_pop;
    job_t job_in, job_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_PERIOD:   cfg_next.packet_period    = pwdata[PERIOD_W-1:0];
                REG_BATCH:    cfg_next.batch_size       = pwdata[NB_W-1:0];
                REG_BUDGET:   cfg_next.total_batches    = pwdata[CNT_W-1:0];
                REG_TOL:      cfg_next.late_tolerance   = pwdata[TOL_W-1:0];
                REG_MAX_LATE: cfg_next.max_late_batches = pwdata[CNT_W-1:0];
                REG_PAYLOAD:  cfg_next.payload_bytes    = pwdata[PAY_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PERIOD:   prdata = DATA_W'(cfg_reg.packet_period);
            REG_BATCH:    prdata = DATA_W'(cfg_reg.batch_size);
            REG_BUDGET:   prdata = DATA_W'(cfg_reg.total_batches);
            REG_TOL:      prdata = DATA_W'(cfg_reg.late_tolerance);
            REG_MAX_LATE: prdata = DATA_W'(cfg_reg.max_late_batches);
            REG_PAYLOAD:  prdata = DATA_W'(cfg_reg.payload_bytes);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dpp_front #(
        .MAX_BATCH (MAX_BATCH),
        .FRAC_BITS (PERIOD_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job_in),
        .q_full    (q_full)
    );

    dpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_valid),
        .din   (job_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (job_out),
        .empty (q_empty)
    );

    dpp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (job_out),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dpp_deadline.sv =====
// next-deadline unit: pipelined base + round(count * period) with saturation
`default_nettype none

module dpp_deadline
    import dpp_pkg::*;
#(
    parameter int MAX_BATCH = 64,
    parameter int FRAC_BITS = 20
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dl_req_t             req,
    input  wire logic [PERIOD_W-1:0] period,
    input  wire logic [TIME_W-1:0]   time_base,
    output logic [TIME_W-1:0]        deadline,
    output logic                     busy
);

    localparam int CW   = CNT_W + $clog2(MAX_BATCH + 1);
    localparam int HW   = CW - 32;
    localparam int PHW  = PERIOD_W - 32;
    localparam int P10W = HW + 32;
    localparam int P11W = HW + PHW;
    localparam int MW   = ((PERIOD_W > P10W) ? PERIOD_W : P10W) + 1;
    localparam int PW   = CW + PERIOD_W + 1;
    localparam int XW   = (PW > TIME_W + 33) ? PW : TIME_W + 33;
    localparam logic [TIME_W-1:0] HALF = TIME_W'(1) << (FRAC_BITS - 1);

    logic [3:0]          stage_v_reg;
    logic [CW-1:0]       count_reg;
    logic [PERIOD_W-1:0] per_reg;
    logic [63:0]         p00_reg;
    logic [PERIOD_W-1:0] p01_reg;
    logic [P10W-1:0]     p10_reg;
    logic [P11W-1:0]     p11_reg;
    logic [TIME_W:0]     lo_reg;
    logic [MW-1:0]       mid_reg;
    logic [P11W-1:0]     hi_reg;
    logic [XW-1:0]       prod_reg;
    logic [TIME_W-1:0]   deadline_reg;
    logic [TIME_W-1:0]   deadline_next;

    logic                ovf;
    logic [TIME_W-1:0]   offset;
    logic [TIME_W:0]     dl_sum;

    always_comb
    begin
        ovf    = |prod_reg[XW-1:TIME_W+FRAC_BITS];
        offset = ovf ? '1 : prod_reg[TIME_W+FRAC_BITS-1:FRAC_BITS];
        dl_sum = {1'b0, time_base} + {1'b0, offset};
        deadline_next = deadline_reg;
        if (req.load)
        begin
            deadline_next = req.load_time;
        end
        else if (stage_v_reg[3])
        begin
            deadline_next = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg  <= '0;
            deadline_reg <= '0;
        end
        else
        begin
            stage_v_reg  <= {stage_v_reg[2:0], req.kick};
            deadline_reg <= deadline_next;
        end
    end

    // datapath: count, partial products, partial sums, full product
    always_ff @(posedge clk)
    begin
        if (req.kick)
        begin
            count_reg <= CW'(req.bidx) * CW'(req.nb);
            per_reg   <= period;
        end
        p00_reg  <= 64'(count_reg[31:0]) * 64'(per_reg[31:0]);
        p01_reg  <= PERIOD_W'(count_reg[31:0]) * PERIOD_W'(per_reg[PERIOD_W-1:32]);
        p10_reg  <= P10W'(count_reg[CW-1:32]) * P10W'(per_reg[31:0]);
        p11_reg  <= P11W'(count_reg[CW-1:32]) * P11W'(per_reg[PERIOD_W-1:32]);
        lo_reg   <= {1'b0, p00_reg} + {1'b0, HALF};
        mid_reg  <= MW'(p01_reg) + MW'(p10_reg);
        hi_reg   <= p11_reg;
        prod_reg <= (XW'(hi_reg) << 64) + (XW'(mid_reg) << 32) + XW'(lo_reg);
    end

    assign deadline = deadline_reg;
    assign busy     = |stage_v_reg;

    a_no_kick_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.kick |-> !busy)
        else $error("deadline kick while previous computation in flight");

endmodule

`default_nettype wire

// ===== rtl/core/dpp_front.sv =====
// front end: accepts items, keeps run state, decides batch releases
`default_nettype none

module dpp_front
    import dpp_pkg::*;
#(
    parameter int MAX_BATCH = 64,
    parameter int FRAC_BITS = 20
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire in_t  item,
    input  wire cfg_t cfg,
    output logic      job_valid,
    output job_t      job,
    input  wire logic q_full
);

    localparam logic [NB_W-1:0] MAX_NB = NB_W'(MAX_BATCH);

    logic              running_reg, running_next;
    logic [TIME_W-1:0] time_base_reg, time_base_next;
    logic [CNT_W-1:0]  bidx_reg, bidx_next;
    logic [CNT_W-1:0]  sent_reg, sent_next;
    logic [CNT_W-1:0]  late_reg, late_next;
    logic [TIME_W-1:0] worst_reg, worst_next;
    logic [TIME_W-1:0] sum_reg, sum_next;

    dl_req_t           dl_req;
    logic [TIME_W-1:0] deadline;
    logic              dl_busy;

    logic              acc, is_start, is_stop, fire;
    logic [NB_W-1:0]   nb_eff;
    logic [CNT_W-1:0]  budget;
    logic [TIME_W-1:0] diff;
    logic              is_late;
    logic [TIME_W:0]   sum_ext;
    logic [CNT_W-1:0]  late_new, bidx_new;
    logic [TIME_W-1:0] worst_new, sum_new;
    logic              done_new;

    function automatic logic [1:0] judge(
        input logic [CNT_W-1:0] bidx,
        input logic [CNT_W-1:0] bud,
        input logic [CNT_W-1:0] late,
        input logic [CNT_W-1:0] max_late
    );
        logic [1:0] v;
        if (bidx < bud)
        begin
            v = VERDICT_SHORT;
        end
        else if (late > max_late)
        begin
            v = VERDICT_LATE;
        end
        else
        begin
            v = VERDICT_OK;
        end
        return v;
    endfunction

    dpp_deadline #(
        .MAX_BATCH (MAX_BATCH),
        .FRAC_BITS (FRAC_BITS)
    ) u_deadline (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (dl_req),
        .period    (cfg.packet_period),
        .time_base (time_base_reg),
        .deadline  (deadline),
        .busy      (dl_busy)
    );

    assign full = q_full || dl_busy;

    always_comb
    begin
        acc      = push && !full;
        is_start = acc && (item.func == FUNC_START);
        is_stop  = acc && (item.func == FUNC_STOP);
        fire     = acc && (item.func == FUNC_STEP) && running_reg && item.sink_ready
                   && (item.now_time >= deadline);

        if (cfg.batch_size == '0)
        begin
            nb_eff = NB_W'(1);
        end
        else if (cfg.batch_size > MAX_NB)
        begin
            nb_eff = MAX_NB;
        end
        else
        begin
            nb_eff = cfg.batch_size;
        end
        budget = (cfg.total_batches == '0) ? CNT_W'(1) : cfg.total_batches;

        diff      = item.now_time - deadline;
        is_late   = diff > TIME_W'(cfg.late_tolerance);
        sum_ext   = {1'b0, sum_reg} + {1'b0, diff};
        late_new  = (is_late && late_reg != '1) ? late_reg + CNT_W'(1) : late_reg;
        worst_new = (is_late && diff > worst_reg) ? diff : worst_reg;
        if (is_late)
        begin
            sum_new = sum_ext[TIME_W] ? '1 : sum_ext[TIME_W-1:0];
        end
        else
        begin
            sum_new = sum_reg;
        end
        bidx_new = bidx_reg + CNT_W'(1);
        done_new = bidx_new >= budget;

        running_next   = running_reg;
        time_base_next = time_base_reg;
        bidx_next      = bidx_reg;
        sent_next      = sent_reg;
        late_next      = late_reg;
        worst_next     = worst_reg;
        sum_next       = sum_reg;

        if (is_start)
        begin
            running_next   = 1'b1;
            time_base_next = item.now_time;
            bidx_next      = '0;
            sent_next      = '0;
            late_next      = '0;
            worst_next     = '0;
            sum_next       = '0;
        end
        if (is_stop)
        begin
            running_next = 1'b0;
        end
        if (fire)
        begin
            bidx_next  = bidx_new;
            sent_next  = sent_reg + CNT_W'(nb_eff);
            late_next  = late_new;
            worst_next = worst_new;
            sum_next   = sum_new;
            if (done_new)
            begin
                running_next = 1'b0;
            end
        end

        dl_req.load      = is_start;
        dl_req.load_time = item.now_time;
        dl_req.kick      = fire;
        dl_req.bidx      = bidx_new;
        dl_req.nb        = nb_eff;

        job_valid      = is_stop || fire;
        job.pkt        = fire;
        job.nb         = fire ? nb_eff : NB_W'(1);
        job.bidx       = fire ? bidx_reg : '0;
        job.stamp      = fire && (cfg.payload_bytes >= STAMP_MIN_BYTES);
        job.late       = fire && is_late;
        job.lateness   = (fire && is_late) ? diff : '0;
        job.sent_base  = sent_reg;
        job.late_count = fire ? late_new : late_reg;
        job.worst      = fire ? worst_new : worst_reg;
        job.sum        = fire ? sum_new : sum_reg;
        job.done       = fire ? done_new : 1'b1;
        job.verdict    = fire ? judge(bidx_new, budget, late_new, cfg.max_late_batches)
                              : judge(bidx_reg, budget, late_reg, cfg.max_late_batches);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            time_base_reg <= '0;
            bidx_reg      <= '0;
            sent_reg      <= '0;
            late_reg      <= '0;
            worst_reg     <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            running_reg   <= running_next;
            time_base_reg <= time_base_next;
            bidx_reg      <= bidx_next;
            sent_reg      <= sent_next;
            late_reg      <= late_next;
            worst_reg     <= worst_next;
            sum_reg       <= sum_next;
        end
    end

    a_release_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job.pkt) |-> running_reg)
        else $error("batch released while no run is active");

    a_release_starts_deadline: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> dl_busy)
        else $error("batch release did not start the next deadline computation");

endmodule

`default_nettype wire

// ===== rtl/core/dpp_queue.sv =====
// short job queue between the front end and the packet emitter
`default_nettype none

module dpp_queue
    import dpp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t din,
    output logic      full,
    input  wire logic pop,
    output job_t      dout,
    output logic      empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= din;
        end
    end

    assign dout  = slot_reg[rd_reg];
    assign full  = cnt_reg == CW'(DEPTH);
    assign empty = cnt_reg == '0;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/core/dpp_back.sv =====
// back end: expands jobs into one result beat per packet behind an output register
`default_nettype none

module dpp_back
    import dpp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire job_t q_job,
    output logic      q_pop,
    output logic      empty,
    input  wire logic pop,
    output out_t      result
);

    logic             act_reg, act_next;
    job_t             job_reg, job_next;
    logic [CNT_W-1:0] seq_reg, seq_next;
    logic [CNT_W-1:0] sent_reg, sent_next;
    logic [NB_W-1:0]  left_reg, left_next;
    logic             out_v_reg, out_v_next;
    out_t             res_reg, res_next;

    logic space, emit, last, fin, load;

    always_comb
    begin
        space = !out_v_reg || pop;
        emit  = act_reg && space;
        last  = left_reg == NB_W'(1);
        fin   = emit && last;
        load  = !q_empty && (!act_reg || fin);
        q_pop = load;

        act_next   = act_reg;
        job_next   = job_reg;
        seq_next   = seq_reg;
        sent_next  = sent_reg;
        left_next  = left_reg;
        out_v_next = out_v_reg;
        res_next   = res_reg;

        if (emit)
        begin
            res_next.pkt_valid      = job_reg.pkt;
            res_next.seq_number     = seq_reg;
            res_next.stamp_seq      = job_reg.stamp;
            res_next.last_of_batch  = last;
            res_next.batch_late     = job_reg.late;
            res_next.lateness       = job_reg.lateness;
            // a status beat reports the count as it stands
            res_next.packets_sent   = job_reg.pkt ? sent_reg + CNT_W'(1) : sent_reg;
            res_next.late_count     = job_reg.late_count;
            res_next.worst_lateness = job_reg.worst;
            res_next.sum_lateness   = job_reg.sum;
            res_next.run_done       = last && job_reg.done;
            res_next.verdict        = last ? job_reg.verdict : VERDICT_OK;
            seq_next   = seq_reg + CNT_W'(1);
            sent_next  = sent_reg + CNT_W'(1);
            left_next  = left_reg - NB_W'(1);
            out_v_next = 1'b1;
        end
        else if (pop)
        begin
            out_v_next = 1'b0;
        end

        if (load)
        begin
            act_next  = 1'b1;
            job_next  = q_job;
            seq_next  = q_job.bidx * CNT_W'(q_job.nb);
            sent_next = q_job.sent_base;
            left_next = q_job.nb;
        end
        else if (fin)
        begin
            act_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            act_reg   <= act_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        seq_reg  <= seq_next;
        sent_reg <= sent_next;
        left_reg <= left_next;
        res_reg  <= res_next;
    end

    assign empty  = !out_v_reg;
    assign result = res_reg;

    a_active_has_packets: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> (left_reg != '0))
        else $error("active job with no packets left");

endmodule

`default_nettype wire

// ===== sim/pacer_checker.sv =====
// checker for the deadline packet pacer: predicts result beats and compares them as they leave
module pacer_checker
    import dpp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic              full,
    input  wire in_t               item,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire out_t              result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output int                     mismatches,
    output int                     beats_owed
);

    localparam int FRAC_BITS = 20;
    localparam int MAX_PKTS  = 64;

    cfg_t              cfg;
    logic [TIME_W-1:0] base_ns;
    logic [TIME_W-1:0] next_offset;
    logic [TIME_W-1:0] worst_ns;
    logic [TIME_W-1:0] late_sum;
    logic [CNT_W-1:0]  batch_idx;
    logic [CNT_W-1:0]  sent_cnt;
    logic [CNT_W-1:0]  late_cnt;
    logic              active;
    out_t              owed_q[$];
    int                fail_cnt;

    function automatic logic [NB_W-1:0] pkts_per_batch(input logic [NB_W-1:0] n);
        if (n == 0)
            return NB_W'(1);
        if (n > MAX_PKTS)
            return NB_W'(MAX_PKTS);
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] batch_budget(input logic [CNT_W-1:0] n);
        return (n == 0) ? CNT_W'(1) : n;
    endfunction

    // rounded count * period with the fraction dropped, saturating at the top of 64 bits
    function automatic logic [TIME_W-1:0] offset_ns(input logic [TIME_W-1:0] count,
                                                     input logic [PERIOD_W-1:0] period);
        logic [127:0] prod;
        prod = 128'(count) * 128'(period) + (128'(1) << (FRAC_BITS - 1));
        if ((prod >> (TIME_W + FRAC_BITS)) != 0)
            return '1;
        return prod[TIME_W+FRAC_BITS-1:FRAC_BITS];
    endfunction

    function automatic logic [1:0] run_verdict();
        if (batch_idx < batch_budget(cfg.total_batches))
            return VERDICT_SHORT;
        if (late_cnt > cfg.max_late_batches)
            return VERDICT_LATE;
        return VERDICT_OK;
    endfunction

    task automatic note_reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        case (addr[ADDR_W-1:3])
            REG_PERIOD:   cfg.packet_period    = value[PERIOD_W-1:0];
            REG_BATCH:    cfg.batch_size       = value[NB_W-1:0];
            REG_BUDGET:   cfg.total_batches    = value[CNT_W-1:0];
            REG_TOL:      cfg.late_tolerance   = value[TOL_W-1:0];
            REG_MAX_LATE: cfg.max_late_batches = value[CNT_W-1:0];
            REG_PAYLOAD:  cfg.payload_bytes    = value[PAY_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic apply_item(input in_t it);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] lness;
        logic [NB_W-1:0]   nb;
        logic              late;
        logic              done;
        logic              last;
        logic [1:0]        verd;
        out_t              beat;
        int                i;
        case (it.func)
            FUNC_START:
            begin
                base_ns     = it.now_time;
                next_offset = '0;
                batch_idx   = '0;
                sent_cnt    = '0;
                late_cnt    = '0;
                worst_ns    = '0;
                late_sum    = '0;
                active      = 1'b1;
            end
            FUNC_STOP:
            begin
                active = 1'b0;
                beat = '0;
                beat.last_of_batch  = 1'b1;
                beat.packets_sent   = sent_cnt;
                beat.late_count     = late_cnt;
                beat.worst_lateness = worst_ns;
                beat.sum_lateness   = late_sum;
                beat.run_done       = 1'b1;
                beat.verdict        = run_verdict();
                owed_q.push_back(beat);
            end
            FUNC_STEP:
            begin
                if (active && it.sink_ready)
                begin
                    sum = {1'b0, base_ns} + {1'b0, next_offset};
                    deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    if (it.now_time >= deadline)
                    begin
                        nb = pkts_per_batch(cfg.batch_size);
                        gap = it.now_time - deadline;
                        late = gap > TIME_W'(cfg.late_tolerance);
                        lness = late ? gap : '0;
                        if (late)
                        begin
                            if (late_cnt != '1)
                                late_cnt++;
                            if (lness > worst_ns)
                                worst_ns = lness;
                            sum = {1'b0, late_sum} + {1'b0, lness};
                            late_sum = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                        end
                        batch_idx++;
                        done = batch_idx >= batch_budget(cfg.total_batches);
                        if (done)
                            active = 1'b0;
                        verd = run_verdict();
                        for (i = 0; i < nb; i++)
                        begin
                            last = (i == nb - 1);
                            sent_cnt++;
                            beat.pkt_valid      = 1'b1;
                            beat.seq_number     = (batch_idx - 1'b1) * CNT_W'(nb) + CNT_W'(i);
                            beat.stamp_seq      = cfg.payload_bytes >= STAMP_MIN_BYTES;
                            beat.last_of_batch  = last;
                            beat.batch_late     = late;
                            beat.lateness       = lness;
                            beat.packets_sent   = sent_cnt;
                            beat.late_count     = late_cnt;
                            beat.worst_lateness = worst_ns;
                            beat.sum_lateness   = late_sum;
                            beat.run_done       = last ? done : 1'b0;
                            beat.verdict        = last ? verd : VERDICT_OK;
                            owed_q.push_back(beat);
                        end
                        next_offset = offset_ns(TIME_W'(batch_idx) * TIME_W'(nb),
                                                cfg.packet_period);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    task automatic compare_beat(input out_t want, input out_t got);
        check_field("pkt_valid", want.pkt_valid, got.pkt_valid);
        check_field("seq_number", want.seq_number, got.seq_number);
        check_field("stamp_seq", want.stamp_seq, got.stamp_seq);
        check_field("last_of_batch", want.last_of_batch, got.last_of_batch);
        check_field("batch_late", want.batch_late, got.batch_late);
        check_field("lateness", want.lateness, got.lateness);
        check_field("packets_sent", want.packets_sent, got.packets_sent);
        check_field("late_count", want.late_count, got.late_count);
        check_field("worst_lateness", want.worst_lateness, got.worst_lateness);
        check_field("sum_lateness", want.sum_lateness, got.sum_lateness);
        check_field("run_done", want.run_done, got.run_done);
        check_field("verdict", want.verdict, got.verdict);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg         = CFG_RESET;
            base_ns     = '0;
            next_offset = '0;
            worst_ns    = '0;
            late_sum    = '0;
            batch_idx   = '0;
            sent_cnt    = '0;
            late_cnt    = '0;
            active      = 1'b0;
            fail_cnt    = 0;
            owed_q.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t: beat with nothing owed, expected none, actual %p",
                             $time, result);
                    fail_cnt++;
                end
                else
                    compare_beat(owed_q.pop_front(), result);
            end
            if (psel && penable && pwrite && pready)
                note_reg_write(paddr, pwdata);
            if (push && !full)
                apply_item(item);
        end
        mismatches <= fail_cnt;
        beats_owed <= owed_q.size();
    end

endmodule

// ===== sim/testbench.sv =====
// top of the deadline packet pacer bench: clock, reset, stimulus, result sink and verdict
module testbench;
    import dpp_pkg::*;

    localparam logic [1:0]        FUNC_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] T_MAX       = '1;
    localparam int                FRAC_BITS   = 20;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              push    = 1'b0;
    logic              full;
    in_t               item    = '0;
    logic              empty;
    logic              pop     = 1'b0;
    out_t              result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                beats_owed;

    int                burst_left = 0;
    bit                no_gaps    = 1'b0;
    int                items_sent = 0;
    logic [TIME_W-1:0] now_ns     = '0;
    logic [TIME_W-1:0] batch_ns   = '0;
    logic [TOL_W-1:0]  tol_ns     = '0;

    int                rx_mode  = 0;
    int                rx_left  = 0;
    int                rx_hold  = 0;
    int                rx_taken = 0;
    bit                rx_held  = 1'b0;

    always #6 clk = ~clk;

    deadline_packet_pacer_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pacer_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .beats_owed (beats_owed)
    );

    function automatic logic [TIME_W-1:0] rand_ns();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TIME_W-1:0] later(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    // psel stays high between writes, each write starts with its own setup cycle
    task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        logic [NB_W-1:0] nb;
        write_reg(REG_PERIOD, DATA_W'(c.packet_period));
        write_reg(REG_BATCH, DATA_W'(c.batch_size));
        write_reg(REG_BUDGET, DATA_W'(c.total_batches));
        write_reg(REG_TOL, DATA_W'(c.late_tolerance));
        write_reg(REG_MAX_LATE, DATA_W'(c.max_late_batches));
        write_reg(REG_PAYLOAD, DATA_W'(c.payload_bytes));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        nb = (c.batch_size == 0) ? NB_W'(1) : (c.batch_size > 64) ? NB_W'(64) : c.batch_size;
        // rough spacing of deadlines, only used to aim the time steps
        batch_ns = (TIME_W'(c.packet_period) * TIME_W'(nb)) >> FRAC_BITS;
        tol_ns = c.late_tolerance;
    endtask

    task automatic settle();
        push <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (beats_owed != 0)
            @(posedge clk);
        // the deadline pipeline may still be busy after a release
        repeat (20)
            @(posedge clk);
    endtask

    task automatic send(input logic [1:0] fn, input logic [TIME_W-1:0] at_ns, input logic ready);
        int gap;
        if (burst_left == 0)
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        item <= '{func: fn, now_time: at_ns, sink_ready: ready};
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        burst_left--;
        if (fn != FUNC_UNUSED)
            items_sent++;
    endtask

    task automatic random_step();
        int                r;
        logic [TIME_W-1:0] adv;
        r = $urandom_range(0, 99);
        if (r < 15)
            adv = '0;
        else if (r < 40)
            adv = rand_ns() % (batch_ns + 1);
        else if (r < 75)
            adv = batch_ns + TIME_W'($urandom_range(0, 1000));
        else if (r < 92)
            adv = batch_ns + TIME_W'(tol_ns) + TIME_W'($urandom_range(1, 5000));
        else
            adv = rand_ns() >> $urandom_range(0, 40);
        now_ns = later(now_ns, adv);
        send(FUNC_STEP, now_ns, 1'($urandom_range(0, 99) < 85));
    endtask

    // one run: a start, a string of time steps with some noise, often a stop
    task automatic random_sequence();
        int                r;
        int                steps;
        logic [1:0]        fn;
        logic [TIME_W-1:0] at;
        r = $urandom_range(0, 9);
        if (r == 0)
            now_ns = '0;
        else if (r == 1)
            now_ns = T_MAX - TIME_W'($urandom_range(0, 100000));
        else
            now_ns = rand_ns() >> $urandom_range(8, 40);
        send(FUNC_START, now_ns, 1'($urandom_range(0, 1)));
        steps = $urandom_range(2, 14);
        repeat (steps)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                fn = 2'($urandom_range(0, 3));
                at = rand_ns();
                if (fn == FUNC_START)
                    now_ns = at;
                send(fn, at, 1'($urandom_range(0, 1)));
            end
            else if (r < 12)
                send(FUNC_STOP, now_ns, 1'($urandom_range(0, 1)));
            else
                random_step();
        end
        if ($urandom_range(0, 1))
            send(FUNC_STOP, now_ns, 1'b1);
    endtask

    function automatic cfg_t pick_config(input int phase);
        cfg_t c;
        case ($urandom_range(0, 4))
            0:       c.packet_period = PERIOD_W'($urandom_range(0, 1 << 24));
            1:       c.packet_period = PERIOD_W'(rand_ns());
            default: c.packet_period = (PERIOD_W'($urandom_range(50, 5000)) << FRAC_BITS)
                                       + PERIOD_W'($urandom_range(0, (1 << FRAC_BITS) - 1));
        endcase
        case ($urandom_range(0, 7))
            0:       c.batch_size = '0;
            1:       c.batch_size = NB_W'(64);
            2:       c.batch_size = '1;
            3:       c.batch_size = NB_W'($urandom);
            default: c.batch_size = NB_W'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 7))
            0:       c.total_batches = '0;
            1:       c.total_batches = CNT_W'(1);
            2:       c.total_batches = CNT_W'(rand_ns());
            default: c.total_batches = CNT_W'($urandom_range(2, 8));
        endcase
        case ($urandom_range(0, 5))
            0:       c.late_tolerance = '0;
            1:       c.late_tolerance = TOL_W'($urandom);
            default: c.late_tolerance = TOL_W'($urandom_range(0, 2000));
        endcase
        case ($urandom_range(0, 5))
            0:       c.max_late_batches = CNT_W'(rand_ns());
            default: c.max_late_batches = CNT_W'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 5))
            0:       c.payload_bytes = STAMP_MIN_BYTES;
            1:       c.payload_bytes = PAY_W'($urandom);
            default: c.payload_bytes = PAY_W'($urandom_range(0, 15));
        endcase
        if (phase == 0)
        begin
            c.packet_period    = '1;
            c.batch_size       = NB_W'(64);
            c.total_batches    = '1;
            c.late_tolerance   = '1;
            c.max_late_batches = '1;
            c.payload_bytes    = '1;
        end
        else if (phase == 1)
        begin
            c.packet_period    = PERIOD_W'(1);
            c.batch_size       = '0;
            c.total_batches    = '0;
            c.late_tolerance   = '0;
            c.max_late_batches = '0;
            c.payload_bytes    = '0;
        end
        else if (phase == 2)
            c.batch_size = '1;
        return c;
    endfunction

    // result sink: stalls in moods of random length, and once holds off long enough to back up
    always @(posedge clk)
    begin
        if (pop && !empty)
            rx_taken++;
        if (!rx_held && rx_taken >= 30)
        begin
            rx_held = 1'b1;
            rx_hold = 400;
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        if (rx_hold != 0)
        begin
            rx_hold--;
            pop <= 1'b0;
        end
        else
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
    end

    initial
    begin : stimulus
        cfg_t c;
        int   phase;
        int   first;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        c = CFG_RESET;
        c.batch_size       = NB_W'(3);
        c.total_batches    = CNT_W'(4);
        c.late_tolerance   = '0;
        c.max_late_batches = CNT_W'(1);
        c.payload_bytes    = PAY_W'(7);
        set_config(c);

        // idle behavior: stop status, unused code, step before any start
        send(FUNC_STOP, '0, 1'b1);
        send(FUNC_UNUSED, T_MAX, 1'b1);
        send(FUNC_STEP, TIME_W'(500), 1'b1);
        // on-time, not-yet, sink busy, late, and budget exhausted with too many late batches
        send(FUNC_START, TIME_W'(100), 1'b0);
        send(FUNC_STEP, TIME_W'(100), 1'b0);
        send(FUNC_STEP, TIME_W'(100), 1'b1);
        send(FUNC_STEP, TIME_W'(3099), 1'b1);
        send(FUNC_STEP, TIME_W'(3100), 1'b1);
        send(FUNC_STEP, TIME_W'(20000), 1'b1);
        send(FUNC_STEP, T_MAX, 1'b1);
        send(FUNC_STEP, T_MAX, 1'b1);
        send(FUNC_STOP, T_MAX, 1'b0);
        // deadline saturates at the top of the time range
        send(FUNC_START, T_MAX - TIME_W'(1000), 1'b1);
        send(FUNC_STEP, T_MAX - TIME_W'(1000), 1'b1);
        send(FUNC_STEP, T_MAX - TIME_W'(1), 1'b1);
        send(FUNC_STEP, T_MAX, 1'b1);
        send(FUNC_STOP, T_MAX, 1'b1);
        // summed lateness saturates, then a restart in mid-run
        send(FUNC_START, '0, 1'b1);
        send(FUNC_STEP, T_MAX, 1'b1);
        send(FUNC_STEP, T_MAX, 1'b1);
        send(FUNC_START, TIME_W'(5), 1'b1);
        send(FUNC_STOP, TIME_W'(5), 1'b1);
        settle();

        for (phase = 0; phase < 7; phase++)
        begin
            set_config(pick_config(phase));
            no_gaps = (phase == 3);
            first = items_sent;
            while (items_sent - first < 24)
                random_sequence();
            settle();
        end

        if (mismatches == 0 && beats_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #24_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
